>>> sv/noc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package noc_pkg;

  localparam int unsigned MaxNucleons = 256;
  localparam int unsigned IdxW        = $clog2(MaxNucleons);
  localparam int unsigned CountW      = 9;
  localparam int unsigned ThreshW     = 34;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned TotalW      = 17;
  localparam int unsigned DrainW      = 2;

  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(135595);
  localparam logic [CountW-1:0]  CountReset  = CountW'(208);
  localparam logic [CountW-1:0]  CountMax    = CountW'(MaxNucleons);
  localparam logic [TotalW-1:0]  TotalMax    = '1;
  // drain counter value at which the last pair's hit has reached the collision count
  localparam logic [DrainW-1:0]  DrainCycles = DrainW'(3);

  typedef enum logic [1:0] {
    OpLoadA = 2'd0,
    OpLoadB = 2'd1,
    OpRun   = 2'd2,
    OpQuery = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CfgThreshold = 1'b0,
    CfgCount     = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StIssue = 3'b010,
    StDrain = 3'b100
  } state_e;

  typedef struct packed {
    op_e                      opcode;
    logic [IdxW-1:0]          index;
    logic signed [CoordW-1:0] x_pos;
    logic signed [CoordW-1:0] y_pos;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [TotalW-1:0] collisions;
    logic              flag_a;
    logic              flag_b;
  } rsp_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pos_t;

  typedef struct packed {
    logic [IdxW-1:0] a_idx;
    logic [IdxW-1:0] b_idx;
  } pair_tag_t;

  typedef struct packed {
    logic      valid;
    logic      hit;
    pair_tag_t tag;
  } pair_res_t;

endpackage

`default_nettype wire

>>> sv/noc_pos_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module noc_pos_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/noc_pair_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module noc_pair_dist (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire noc_pkg::pair_tag_t             tag_i,
  input  wire noc_pkg::pos_t                  a_pos_i,
  input  wire noc_pkg::pos_t                  b_pos_i,
  input  wire logic [noc_pkg::ThreshW-1:0]    thresh_i,
  output noc_pkg::pair_res_t                  res_o
);

  localparam int unsigned CW = noc_pkg::CoordW;
  localparam int unsigned SqW = 2 * CW;

  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        ax, ay;
  logic [SqW-1:0]       sq_x_d, sq_y_d, sq_x_q, sq_y_q;
  logic                 vld_q;
  noc_pkg::pair_tag_t   tag_q;
  logic [SqW:0]         sum;
  noc_pkg::pair_res_t   res_d, res_q;

  // stage 1: differences and squares
  assign dx = $signed({b_pos_i.x[CW-1], b_pos_i.x}) - $signed({a_pos_i.x[CW-1], a_pos_i.x});
  assign dy = $signed({b_pos_i.y[CW-1], b_pos_i.y}) - $signed({a_pos_i.y[CW-1], a_pos_i.y});
  assign ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign sq_x_d = ax * ax;
  assign sq_y_d = ay * ay;

  always_ff @(posedge clk_i) begin
    sq_x_q <= sq_x_d;
    sq_y_q <= sq_y_d;
    tag_q  <= tag_i;
  end

  // stage 2: sum and threshold compare
  assign sum = {1'b0, sq_x_q} + {1'b0, sq_y_q};

  always_comb begin
    res_d.valid = vld_q;
    res_d.hit   = {{(noc_pkg::ThreshW - SqW - 1){1'b0}}, sum} < thresh_i;
    res_d.tag   = tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      res_q <= '0;
    end else begin
      vld_q <= valid_i;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> sv/nucleon_overlap_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// loads and queries: one per cycle while not busy, result strobed in the cycle after acceptance
// run: busy while all n*n pairs are issued and drained (n = nucleon_count, at most 256), one pair per cycle
//   set by the single read port of each position ram; result strobed as busy falls
// the receiver cannot stall; every command gives exactly one result
// reset (async, active low): registers to defaults, count cleared, flags read as zero
//   until a run, position rams hold unknown data until loaded

module nucleon_overlap_counter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire noc_pkg::cmd_t                 cmd_i,
  output logic                               rsp_valid_o,
  output noc_pkg::rsp_t                      rsp_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [0:0]                    cfg_index_i,
  input  wire logic [noc_pkg::ThreshW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW   = noc_pkg::IdxW;
  localparam int unsigned CountW = noc_pkg::CountW;

  logic [noc_pkg::ThreshW-1:0]   thresh_q;
  logic [CountW-1:0]             count_q;
  logic [CountW-1:0]             n_eff, n_last;
  logic                          accept, run_acc, in_range;
  noc_pkg::state_e               state_q, state_d;
  logic [IdxW-1:0]               a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [noc_pkg::DrainW-1:0]    drain_q, drain_d;
  logic                          rd_en, rd_vld_q, drain_done;
  noc_pkg::pair_tag_t            tag_q;
  noc_pkg::pos_t                 a_rdata, b_rdata;
  noc_pkg::pos_t                 wpos;
  noc_pkg::pair_res_t            res;
  logic                          a_flag_mem [noc_pkg::MaxNucleons];
  logic                          b_flag_mem [noc_pkg::MaxNucleons];
  logic                          a_flag_rd_q, b_flag_rd_q;
  logic [CountW-1:0]             run_n_q;
  logic                          b_acc_q, b_acc_d;
  logic                          row_first, col_first, row_last, qry_rd;
  logic [noc_pkg::TotalW-1:0]    total_q;
  logic                          rsp_valid_q, rsp_valid_d;
  noc_pkg::rsp_t                 rsp_q, rsp_d;
  logic                          last_a, last_b;

  assign busy_o      = (state_q != noc_pkg::StIdle);
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;
  assign run_acc     = accept && (cmd_i.opcode == noc_pkg::OpRun);
  assign n_eff       = (count_q > noc_pkg::CountMax) ? noc_pkg::CountMax : count_q;
  assign n_last      = n_eff - CountW'(1);
  assign in_range    = {1'b0, cmd_i.index} < n_eff;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= noc_pkg::ThreshReset;
      count_q  <= noc_pkg::CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        noc_pkg::CfgThreshold: thresh_q <= cfg_data_i;
        noc_pkg::CfgCount:     count_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // position stores
  assign wpos.x = cmd_i.x_pos;
  assign wpos.y = cmd_i.y_pos;

  noc_pos_ram #(
    .Width ($bits(noc_pkg::pos_t)),
    .Depth (noc_pkg::MaxNucleons)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_range && (cmd_i.opcode == noc_pkg::OpLoadA)),
    .waddr_i (cmd_i.index),
    .wdata_i (wpos),
    .re_i    (rd_en),
    .raddr_i (a_cnt_q),
    .rdata_o (a_rdata)
  );

  noc_pos_ram #(
    .Width ($bits(noc_pkg::pos_t)),
    .Depth (noc_pkg::MaxNucleons)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_range && (cmd_i.opcode == noc_pkg::OpLoadB)),
    .waddr_i (cmd_i.index),
    .wdata_i (wpos),
    .re_i    (rd_en),
    .raddr_i (b_cnt_q),
    .rdata_o (b_rdata)
  );

  // run sequencer
  assign last_a     = ({1'b0, a_cnt_q} == n_last);
  assign last_b     = ({1'b0, b_cnt_q} == n_last);
  assign rd_en      = (state_q == noc_pkg::StIssue);
  assign drain_done = (state_q == noc_pkg::StDrain) && (drain_q == noc_pkg::DrainCycles);

  always_comb begin
    state_d = state_q;
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    drain_d = drain_q;
    unique case (state_q)
      noc_pkg::StIdle: begin
        if (run_acc) begin
          a_cnt_d = '0;
          b_cnt_d = '0;
          drain_d = '0;
          state_d = (n_eff == '0) ? noc_pkg::StDrain : noc_pkg::StIssue;
        end
      end
      noc_pkg::StIssue: begin
        if (last_a) begin
          a_cnt_d = '0;
          if (last_b) begin
            drain_d = '0;
            state_d = noc_pkg::StDrain;
          end else begin
            b_cnt_d = b_cnt_q + IdxW'(1);
          end
        end else begin
          a_cnt_d = a_cnt_q + IdxW'(1);
        end
      end
      noc_pkg::StDrain: begin
        if (drain_done) begin
          state_d = noc_pkg::StIdle;
        end else begin
          drain_d = drain_q + noc_pkg::DrainW'(1);
        end
      end
      default: state_d = noc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= noc_pkg::StIdle;
      a_cnt_q  <= '0;
      b_cnt_q  <= '0;
      drain_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      a_cnt_q  <= a_cnt_d;
      b_cnt_q  <= b_cnt_d;
      drain_q  <= drain_d;
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q.a_idx <= a_cnt_q;
    tag_q.b_idx <= b_cnt_q;
  end

  noc_pair_dist u_pair (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rd_vld_q),
    .tag_i    (tag_q),
    .a_pos_i  (a_rdata),
    .b_pos_i  (b_rdata),
    .thresh_i (thresh_q),
    .res_o    (res)
  );

  // participant flags and collision count
  // the first row rewrites every a flag and each row ends with one b flag write
  assign row_first = (res.tag.b_idx == '0);
  assign col_first = (res.tag.a_idx == '0);
  assign row_last  = ({1'b0, res.tag.a_idx} == n_last);
  assign b_acc_d   = col_first ? res.hit : (b_acc_q || res.hit);
  assign qry_rd    = accept && in_range && (cmd_i.opcode == noc_pkg::OpQuery) &&
                     ({1'b0, cmd_i.index} < run_n_q);

  always_ff @(posedge clk_i) begin
    if (res.valid && (row_first || res.hit)) begin
      a_flag_mem[res.tag.a_idx] <= res.hit;
    end
    if (res.valid && row_last) begin
      b_flag_mem[res.tag.b_idx] <= b_acc_d;
    end
    if (qry_rd) begin
      a_flag_rd_q <= a_flag_mem[cmd_i.index];
      b_flag_rd_q <= b_flag_mem[cmd_i.index];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_n_q <= '0;
      b_acc_q <= 1'b0;
    end else begin
      if (run_acc) begin
        run_n_q <= n_eff;
      end
      if (res.valid) begin
        b_acc_q <= b_acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
    end else if (run_acc) begin
      total_q  <= '0;
    end else if (res.valid && res.hit) begin
      if (total_q != noc_pkg::TotalMax) begin
        total_q <= total_q + noc_pkg::TotalW'(1);
      end
    end
  end

  // result register
  always_comb begin
    rsp_valid_d     = drain_done || (accept && (cmd_i.opcode != noc_pkg::OpRun));
    rsp_d.collisions = total_q;
    rsp_d.status    = accept && (cmd_i.opcode != noc_pkg::OpRun) && !in_range;
    rsp_d.flag_a    = qry_rd;
    rsp_d.flag_b    = qry_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    rsp_o        = rsp_q;
    rsp_o.flag_a = rsp_q.flag_a && a_flag_rd_q;
    rsp_o.flag_b = rsp_q.flag_b && b_flag_rd_q;
  end

endmodule

`default_nettype wire

>>> sv/noc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module noc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start_i,
  input wire logic                        busy_o,
  input wire noc_pkg::cmd_t               cmd_i,
  input wire logic                        rsp_valid_o,
  input wire noc_pkg::rsp_t               rsp_o
);

  // a load or query transaction answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.opcode != noc_pkg::OpRun) |=> rsp_valid_o)
    else $error("load or query gave no result");

  // a run holds the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.opcode == noc_pkg::OpRun) |=> busy_o)
    else $error("run did not raise busy");

  // no result while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !rsp_valid_o)
    else $error("result during run");

  // end of a run delivers its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> rsp_valid_o)
    else $error("run ended without result");

  // an out of range index never reports flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status) |-> (!rsp_o.flag_a && !rsp_o.flag_b))
    else $error("flags set on error result");

endmodule

bind nucleon_overlap_counter noc_checker u_noc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cmd_i       (cmd_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

`default_nettype wire

>>> test/nucleon_overlap_counter_tb.sv
`timescale 1ns / 1ps

module nucleon_overlap_counter_tb;

  typedef struct packed {
    logic                         is_cfg;
    noc_pkg::cfg_idx_e            reg_sel;
    logic [noc_pkg::ThreshW-1:0]  data;
    noc_pkg::cmd_t                cmd;
    logic                         fixed;
    noc_pkg::rsp_t                rsp;
  } step_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  noc_pkg::cmd_t               cmd_i;
  logic                        rsp_valid_o;
  noc_pkg::rsp_t               rsp_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [0:0]                  cfg_index_i;
  logic [noc_pkg::ThreshW-1:0] cfg_data_i;

  // predictor state
  logic [noc_pkg::ThreshW-1:0]       pred_thresh;
  logic [noc_pkg::CountW-1:0]        pred_count;
  logic signed [noc_pkg::CoordW-1:0] ax_mem [noc_pkg::MaxNucleons];
  logic signed [noc_pkg::CoordW-1:0] ay_mem [noc_pkg::MaxNucleons];
  logic signed [noc_pkg::CoordW-1:0] bx_mem [noc_pkg::MaxNucleons];
  logic signed [noc_pkg::CoordW-1:0] by_mem [noc_pkg::MaxNucleons];
  logic [noc_pkg::MaxNucleons-1:0]   part_a;
  logic [noc_pkg::MaxNucleons-1:0]   part_b;
  logic [noc_pkg::TotalW-1:0]        coll_total;

  noc_pkg::rsp_t nucleon_rsp_q [$];
  step_t         dir_q [$];
  int unsigned   sent_items;
  int            err_count;
  bit            fixed_valid;
  noc_pkg::rsp_t fixed_rsp;

  nucleon_overlap_counter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int eff_count();
    return (pred_count > noc_pkg::CountMax) ? int'(noc_pkg::MaxNucleons) : int'(pred_count);
  endfunction

  function automatic noc_pkg::rsp_t apply_nucleon_cmd(noc_pkg::cmd_t c);
    noc_pkg::rsp_t r;
    int            n;
    longint        dx;
    longint        dy;
    longint        d2;
    r = '0;
    n = eff_count();
    if (c.opcode == noc_pkg::OpRun) begin
      part_a     = '0;
      part_b     = '0;
      coll_total = '0;
      for (int l = 0; l < n; l++) begin
        for (int m = 0; m < n; m++) begin
          dx = longint'(bx_mem[l]) - longint'(ax_mem[m]);
          dy = longint'(by_mem[l]) - longint'(ay_mem[m]);
          d2 = dx * dx + dy * dy;
          if (d2 < longint'(pred_thresh)) begin
            part_a[m] = 1'b1;
            part_b[l] = 1'b1;
            if (coll_total != noc_pkg::TotalMax) coll_total = coll_total + 1'b1;
          end
        end
      end
    end else if (int'(c.index) >= n) begin
      r.status = 1'b1;
    end else begin
      case (c.opcode)
        noc_pkg::OpLoadA: begin
          ax_mem[c.index] = c.x_pos;
          ay_mem[c.index] = c.y_pos;
        end
        noc_pkg::OpLoadB: begin
          bx_mem[c.index] = c.x_pos;
          by_mem[c.index] = c.y_pos;
        end
        default: begin
          r.flag_a = part_a[c.index];
          r.flag_b = part_b[c.index];
        end
      endcase
    end
    r.collisions = coll_total;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // transaction monitor and scoreboard
  always @(posedge clk_i) begin : mon
    noc_pkg::rsp_t got_r;
    noc_pkg::rsp_t want_r;
    if (rst_ni) begin
      if (rsp_valid_o) begin
        got_r = rsp_o;
        if (nucleon_rsp_q.size() == 0) begin
          report_mismatch("result with nothing pending, collisions", got_r.collisions, 0);
        end else begin
          want_r = nucleon_rsp_q.pop_front();
          if (got_r.status !== want_r.status)
            report_mismatch("status", got_r.status, want_r.status);
          if (got_r.collisions !== want_r.collisions)
            report_mismatch("collisions", got_r.collisions, want_r.collisions);
          if (got_r.flag_a !== want_r.flag_a)
            report_mismatch("flag_a", got_r.flag_a, want_r.flag_a);
          if (got_r.flag_b !== want_r.flag_b)
            report_mismatch("flag_b", got_r.flag_b, want_r.flag_b);
        end
      end
      if (start_i && !busy_o) begin
        want_r = apply_nucleon_cmd(cmd_i);
        if (fixed_valid) want_r = fixed_rsp;
        nucleon_rsp_q.push_back(want_r);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == noc_pkg::CfgThreshold) pred_thresh = cfg_data_i;
        else pred_count = cfg_data_i[noc_pkg::CountW-1:0];
      end
    end
  end

  function automatic bit take_gap();
    if (sent_items >= 600 && sent_items < 1000) return 1'b0;
    return $urandom_range(0, 99) < 24;
  endfunction

  task automatic send_cmd(input noc_pkg::cmd_t c);
    if (take_gap()) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i = 1'b1;
    cmd_i   = c;
    do @(posedge clk_i); while (busy_o);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input noc_pkg::cfg_idx_e sel,
                           input logic [noc_pkg::ThreshW-1:0] data);
    start_i = 1'b0;
    while (nucleon_rsp_q.size() != 0 || busy_o) @(negedge clk_i);
    if (take_gap()) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic step_t mk(noc_pkg::op_e op, int idx, int x, int y);
    step_t s;
    s = '0;
    s.cmd.opcode = op;
    s.cmd.index  = noc_pkg::IdxW'(idx);
    s.cmd.x_pos  = noc_pkg::CoordW'(x);
    s.cmd.y_pos  = noc_pkg::CoordW'(y);
    return s;
  endfunction

  function automatic step_t mkx(noc_pkg::op_e op, int idx, int x, int y, int st, int coll);
    step_t s;
    s = mk(op, idx, x, y);
    s.fixed          = 1'b1;
    s.rsp.status     = st[0];
    s.rsp.collisions = noc_pkg::TotalW'(coll);
    return s;
  endfunction

  function automatic step_t mkc(noc_pkg::cfg_idx_e sel, logic [noc_pkg::ThreshW-1:0] data);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.reg_sel = sel;
    s.data    = data;
    return s;
  endfunction

  function automatic logic signed [noc_pkg::CoordW-1:0] rand_coord(int spread);
    if (spread == 0 || $urandom_range(0, 19) == 0) return noc_pkg::CoordW'($urandom());
    return noc_pkg::CoordW'(int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic noc_pkg::cmd_t random_cmd(int n, int spread);
    noc_pkg::cmd_t c;
    int unsigned   sel;
    c.x_pos = rand_coord(spread);
    c.y_pos = rand_coord(spread);
    c.index = noc_pkg::IdxW'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 35) c.opcode = noc_pkg::OpLoadA;
    else if (sel < 70) c.opcode = noc_pkg::OpLoadB;
    else if (sel < 80) c.opcode = noc_pkg::OpRun;
    else c.opcode = noc_pkg::OpQuery;
    if (n != 0 && $urandom_range(0, 9) != 0) c.index = noc_pkg::IdxW'($urandom_range(0, n - 1));
    return c;
  endfunction

  function automatic logic [noc_pkg::ThreshW-1:0] pick_threshold();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return noc_pkg::ThreshReset;
    if (sel < 70) return noc_pkg::ThreshW'($urandom_range(0, 600000));
    if (sel < 80) return '0;
    if (sel < 90) return '1;
    return {2'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [noc_pkg::CountW-1:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 65) return noc_pkg::CountW'($urandom_range(1, 16));
    if (sel < 90) return noc_pkg::CountW'($urandom_range(17, 48));
    return noc_pkg::CountW'(2);
  endfunction

  initial begin : main
    noc_pkg::cmd_t c;
    int            spread;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    sent_items  = 0;
    err_count   = 0;
    fixed_valid = 1'b0;
    fixed_rsp   = '0;
    pred_thresh = noc_pkg::ThreshReset;
    pred_count  = noc_pkg::CountReset;
    part_a      = '0;
    part_b      = '0;
    coll_total  = '0;
    for (int i = 0; i < int'(noc_pkg::MaxNucleons); i++) begin
      ax_mem[i] = '0;
      ay_mem[i] = '0;
      bx_mem[i] = '0;
      by_mem[i] = '0;
    end

    dir_q = '{
      mkx(noc_pkg::OpQuery, 0, 0, 0, 0, 0),
      mkx(noc_pkg::OpQuery, 207, 0, 0, 0, 0),
      mkx(noc_pkg::OpQuery, 208, 0, 0, 1, 0),
      mkx(noc_pkg::OpLoadA, 255, 32767, -32768, 1, 0),
      mkc(noc_pkg::CfgCount, noc_pkg::ThreshW'(3)),
      mkx(noc_pkg::OpLoadA, 0, 32767, -32768, 0, 0),
      mkx(noc_pkg::OpLoadA, 1, -32768, 32767, 0, 0),
      mkx(noc_pkg::OpLoadA, 2, 0, 0, 0, 0),
      mkx(noc_pkg::OpLoadB, 0, 32767, -32768, 0, 0),
      mkx(noc_pkg::OpLoadB, 1, 32767, -32768, 0, 0),
      mkx(noc_pkg::OpLoadB, 2, 256, 0, 0, 0),
      mkx(noc_pkg::OpLoadB, 3, 0, 0, 1, 0),
      mk(noc_pkg::OpRun, 0, 0, 0),
      mk(noc_pkg::OpQuery, 1, 0, 0),
      mk(noc_pkg::OpQuery, 2, 0, 0),
      // distance exactly on the limit must not count
      mkc(noc_pkg::CfgThreshold, noc_pkg::ThreshW'(65536)),
      mk(noc_pkg::OpRun, 0, 0, 0),
      mk(noc_pkg::OpQuery, 2, 0, 0),
      mkc(noc_pkg::CfgThreshold, '0),
      mkx(noc_pkg::OpRun, 0, 0, 0, 0, 0),
      mkx(noc_pkg::OpQuery, 0, 0, 0, 0, 0),
      mkc(noc_pkg::CfgThreshold, '1),
      mkx(noc_pkg::OpRun, 255, -1, -1, 0, 9),
      mk(noc_pkg::OpQuery, 1, 0, 0),
      mkc(noc_pkg::CfgCount, '0),
      mkx(noc_pkg::OpRun, 0, 0, 0, 0, 0),
      mkx(noc_pkg::OpQuery, 0, 0, 0, 1, 0),
      mkx(noc_pkg::OpLoadB, 0, 1, 1, 1, 0)
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        write_reg(dir_q[i].reg_sel, dir_q[i].data);
      end else begin
        fixed_valid = dir_q[i].fixed;
        fixed_rsp   = dir_q[i].rsp;
        send_cmd(dir_q[i].cmd);
        fixed_valid = 1'b0;
      end
    end

    // full nuclei: every slot of both stores gets a position
    write_reg(noc_pkg::CfgThreshold, noc_pkg::ThreshReset);
    write_reg(noc_pkg::CfgCount, noc_pkg::ThreshW'(noc_pkg::MaxNucleons));
    for (int i = 0; i < int'(noc_pkg::MaxNucleons); i++) begin
      c.index  = noc_pkg::IdxW'(i);
      c.opcode = noc_pkg::OpLoadA;
      c.x_pos  = rand_coord(1024);
      c.y_pos  = rand_coord(1024);
      send_cmd(c);
      c.opcode = noc_pkg::OpLoadB;
      c.x_pos  = rand_coord(1024);
      c.y_pos  = rand_coord(1024);
      send_cmd(c);
    end
    c = '0;
    c.opcode = noc_pkg::OpRun;
    send_cmd(c);
    for (int i = 0; i < 6; i++) begin
      c.opcode = noc_pkg::OpQuery;
      c.index  = noc_pkg::IdxW'($urandom());
      send_cmd(c);
    end

    // saturated count with every pair in range
    write_reg(noc_pkg::CfgThreshold, '1);
    write_reg(noc_pkg::CfgCount, {25'($urandom()), 9'h1ff});
    c.opcode = noc_pkg::OpRun;
    send_cmd(c);
    c.opcode = noc_pkg::OpQuery;
    c.index  = '1;
    send_cmd(c);
    c.index  = '0;
    send_cmd(c);

    for (int p = 0; p < 15; p++) begin
      write_reg(noc_pkg::CfgThreshold, pick_threshold());
      write_reg(noc_pkg::CfgCount, {25'($urandom()), pick_count()});
      spread = ($urandom_range(0, 9) < 7) ? int'($urandom_range(200, 1500)) : 0;
      for (int k = 0; k < 80; k++) send_cmd(random_cmd(eff_count(), spread));
    end

    start_i = 1'b0;
    while (nucleon_rsp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (err_count == 0 && nucleon_rsp_q.size() == 0) begin
      $display("** nucleon_overlap_counter: PASSED **");
    end else begin
      $display("** nucleon_overlap_counter: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(50_000_000);
    $display("timeout with %0d results pending", nucleon_rsp_q.size());
    $display("** nucleon_overlap_counter: FAILED **");
    $finish;
  end

endmodule

>>> files.f
sv/noc_pkg.sv
sv/noc_pos_ram.sv
sv/noc_pair_dist.sv
sv/nucleon_overlap_counter.sv
sv/noc_checker.sv
test/nucleon_overlap_counter_tb.sv
